>>> rtl/quadratic_probe_hash_table_assert.svh
// Assertion helpers for the hash table blocks.
// Every macro samples on the rising edge of clk and is disabled during rst.
`ifndef QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH

// The condition holds at every edge.
`define QPHT_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: invariant failed");

// The consequent holds in the same cycle as the antecedent.
`define QPHT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// The consequent holds in the cycle after the antecedent.
`define QPHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/qpht_pkg.sv
`default_nettype none

package qpht_pkg;

  // Table geometry; the slot count is a power of two, so modulo is a wrap
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int KEY_W       = 32;

  // Operation codes carried on the input tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    RES_INSERTED  = 2'd0,
    RES_FOUND     = 2'd1,
    RES_NOT_FOUND = 2'd2,
    RES_FULL      = 2'd3
  } res_status_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PRIME = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic        load;       // capture key and start the probe sequence
    logic        advance;    // read the current probe slot and step on
    logic        write;      // store key into the slot under check
    logic        finish;     // capture result status and slot
    logic        take_slot;  // result slot is the slot under check
    res_status_t code;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;       // occupancy has reached the slot count
    logic slot_used;  // slot under check holds a key
    logic key_match;  // key in slot under check equals the item key
    logic last_probe; // slot under check is the final probe
    logic search;     // current item is a search
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/qpht_ctrl.sv
`default_nettype none

module qpht_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_op,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire qpht_pkg::dp_sts_t sts,
  output qpht_pkg::cmd_t        cmd
);

  qpht_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qpht_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.code      = qpht_pkg::RES_NOT_FOUND;
    case (state)
      qpht_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == qpht_pkg::OP_INSERT && sts.full) begin
            cmd.finish = 1'b1;
            cmd.code   = qpht_pkg::RES_FULL;
            state_next = qpht_pkg::ST_OUT;
          end else begin
            state_next = qpht_pkg::ST_PRIME;
          end
        end
      end
      qpht_pkg::ST_PRIME: begin
        // fetch the home slot
        cmd.advance = 1'b1;
        state_next  = qpht_pkg::ST_CHECK;
      end
      qpht_pkg::ST_CHECK: begin
        if (!sts.search) begin
          if (!sts.slot_used) begin
            cmd.write     = 1'b1;
            cmd.finish    = 1'b1;
            cmd.take_slot = 1'b1;
            cmd.code      = qpht_pkg::RES_INSERTED;
            state_next    = qpht_pkg::ST_OUT;
          end else if (sts.last_probe) begin
            cmd.finish = 1'b1;
            cmd.code   = qpht_pkg::RES_FULL;
            state_next = qpht_pkg::ST_OUT;
          end else begin
            cmd.advance = 1'b1;
          end
        end else begin
          if (!sts.slot_used || (sts.last_probe && !sts.key_match)) begin
            cmd.finish = 1'b1;
            cmd.code   = qpht_pkg::RES_NOT_FOUND;
            state_next = qpht_pkg::ST_OUT;
          end else if (sts.key_match) begin
            cmd.finish    = 1'b1;
            cmd.take_slot = 1'b1;
            cmd.code      = qpht_pkg::RES_FOUND;
            state_next    = qpht_pkg::ST_OUT;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      qpht_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next = qpht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = qpht_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state == qpht_pkg::ST_IDLE);
  assign out_valid = (state == qpht_pkg::ST_OUT);

endmodule

`default_nettype wire

>>> rtl/qpht_dp.sv
`default_nettype none

module qpht_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire qpht_pkg::cmd_t               cmd,
  input  wire logic                         in_op,
  input  wire logic [qpht_pkg::KEY_W-1:0]   in_key,
  output qpht_pkg::dp_sts_t                 sts,
  output qpht_pkg::res_status_t             res_status,
  output logic [qpht_pkg::SLOT_W-1:0]       res_slot,
  output logic [qpht_pkg::CNT_W-1:0]        fill
);

  logic [qpht_pkg::KEY_W-1:0]  slot_keys [qpht_pkg::TABLE_SLOTS];
  logic [qpht_pkg::TABLE_SLOTS-1:0] slot_valid;

  logic [qpht_pkg::KEY_W-1:0]  key_q;
  logic                        op_q;
  logic [qpht_pkg::SLOT_W-1:0] probe;      // slot to fetch next
  logic [qpht_pkg::SLOT_W-1:0] step;       // 2i+1, distance to next square
  logic [qpht_pkg::SLOT_W-1:0] probe_idx;  // probe number of probe
  logic [qpht_pkg::SLOT_W-1:0] chk_slot;   // slot whose contents are in rd_*
  logic [qpht_pkg::SLOT_W-1:0] chk_idx;
  logic [qpht_pkg::KEY_W-1:0]  rd_key;
  logic                        rd_vld;

  // Probe sequencing: (i+1)^2 = i^2 + 2i + 1, wrapping at the slot count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q     <= in_key;
      op_q      <= in_op;
      probe     <= in_key[qpht_pkg::SLOT_W-1:0];
      step      <= qpht_pkg::SLOT_W'(1);
      probe_idx <= '0;
    end else if (cmd.advance) begin
      probe     <= probe + step;
      step      <= step + qpht_pkg::SLOT_W'(2);
      probe_idx <= probe_idx + qpht_pkg::SLOT_W'(1);
      chk_slot  <= probe;
      chk_idx   <= probe_idx;
    end
  end

  // Key store: registered read of the probed slot, write of a new key
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      rd_key <= slot_keys[probe];
    end
    if (cmd.write) begin
      slot_keys[chk_slot] <= key_q;
    end
  end

  // Valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      fill       <= '0;
      rd_vld     <= 1'b0;
    end else begin
      if (cmd.advance) begin
        rd_vld <= slot_valid[probe];
      end
      if (cmd.write) begin
        slot_valid[chk_slot] <= 1'b1;
        fill                 <= fill + qpht_pkg::CNT_W'(1);
      end
    end
  end

  // Result capture
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status <= cmd.code;
      res_slot   <= cmd.take_slot ? chk_slot : '0;
    end
  end

  assign sts.full       = (fill == qpht_pkg::CNT_W'(qpht_pkg::TABLE_SLOTS));
  assign sts.slot_used  = rd_vld;
  assign sts.key_match  = (rd_key == key_q);
  assign sts.last_probe = (chk_idx == qpht_pkg::SLOT_W'(qpht_pkg::TABLE_SLOTS - 1));
  assign sts.search     = (op_q == qpht_pkg::OP_SEARCH);

`include "quadratic_probe_hash_table_assert.svh"

  `QPHT_ASSERT_ALWAYS(a_fill_tracks_valid, $countones(slot_valid) == int'(fill))
  `QPHT_ASSERT_IMPLY(a_write_empty_slot, cmd.write, !rd_vld && !slot_valid[chk_slot])
  `QPHT_ASSERT_NEXT(a_write_bumps_fill, cmd.write, fill == $past(fill) + qpht_pkg::CNT_W'(1))

endmodule

`default_nettype wire

>>> rtl/quadratic_probe_hash_table.sv
// An insert into a full table gives its result in the cycle after the transfer; otherwise
// the home slot is fetched, then one slot is checked per probe made (1 to 16 probes).
// Throughput: one item at a time; the next transfer is taken the cycle after the
// result transfer. One probe per cycle, set by the single read port of the key store.
// Reset clears the controller, all slot valid bits and the occupancy count at once.
`default_nettype none

module quadratic_probe_hash_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] key
  input  wire logic [0:0]  s_tuser,   // [0] operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [3:0] slot, [8:4] occupied, [15:9] zero
  output logic [1:0]       m_tuser    // [1:0] status
);

  qpht_pkg::cmd_t                   cmd;
  qpht_pkg::dp_sts_t                sts;
  qpht_pkg::res_status_t            res_status;
  logic [qpht_pkg::SLOT_W-1:0]      res_slot;
  logic [qpht_pkg::CNT_W-1:0]       fill;

  qpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_op     (s_tuser[0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qpht_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_op      (s_tuser[0]),
    .in_key     (s_tdata),
    .sts        (sts),
    .res_status (res_status),
    .res_slot   (res_slot),
    .fill       (fill)
  );

  // Pack the result
  assign m_tdata = {7'd0, 5'(fill), 4'(res_slot)};
  assign m_tuser = res_status;

endmodule

`default_nettype wire

>>> bench/quadratic_probe_hash_table_tb.sv
`timescale 1ns / 100ps

module quadratic_probe_hash_table_tb;

  localparam int N_RANDOM     = 1680;
  localparam int N_CALM       = 200;   // final items sent with no idling on either side
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int PRINT_LIMIT  = 40;

  // One result of the table, as the block should return it
  typedef struct {
    qpht_pkg::res_status_t       status;
    logic [qpht_pkg::SLOT_W-1:0] slot;
    logic [qpht_pkg::CNT_W-1:0]  occupied;
  } table_reply_t;

  // One directed row; typed rows carry a result that is obvious by hand
  typedef struct {
    logic         op;
    logic [31:0]  key;
    bit           typed;
    table_reply_t reply;
  } probe_row_t;

  localparam int N_DIR = 19;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  // Shadow copy of the table
  logic [31:0]                shadow_keys [qpht_pkg::TABLE_SLOTS];
  logic                       shadow_valid [qpht_pkg::TABLE_SLOTS];
  logic [qpht_pkg::CNT_W-1:0] shadow_fill;

  table_reply_t replies_due [$];
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           items_sent = 0;
  int           status_seen [4] = '{0, 0, 0, 0};
  bit           idle_on = 1'b1;
  int           stall_left = 0;

  probe_row_t directed_rows [N_DIR] = '{
    // empty table
    '{qpht_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, '{qpht_pkg::RES_NOT_FOUND, 4'd0, 5'd0}},
    '{qpht_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd1}},
    '{qpht_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{qpht_pkg::RES_INSERTED, 4'd15, 5'd2}},
    '{qpht_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b1, '{qpht_pkg::RES_FOUND, 4'd15, 5'd2}},
    '{qpht_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, '{qpht_pkg::RES_FOUND, 4'd0, 5'd2}},
    // fill every slot reachable from home zero
    '{qpht_pkg::OP_INSERT, 32'h0000_0010, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    '{qpht_pkg::OP_INSERT, 32'h0000_0020, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    '{qpht_pkg::OP_INSERT, 32'h0000_0030, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    // no empty slot on the probe path while the table still has room
    '{qpht_pkg::OP_INSERT, 32'h8000_0000, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    // search runs out of probes without meeting an empty slot
    '{qpht_pkg::OP_SEARCH, 32'h8000_0000, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    '{qpht_pkg::OP_SEARCH, 32'h0000_0030, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    // duplicate key lands further along; search still finds the first
    '{qpht_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    '{qpht_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    '{qpht_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    '{qpht_pkg::OP_INSERT, 32'h5555_5555, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    '{qpht_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    '{qpht_pkg::OP_SEARCH, 32'hAAAA_AAAA, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    '{qpht_pkg::OP_SEARCH, 32'h5555_555A, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}},
    '{qpht_pkg::OP_SEARCH, 32'h0000_0001, 1'b0, '{qpht_pkg::RES_INSERTED, 4'd0, 5'd0}}
  };

  quadratic_probe_hash_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Walk the quadratic probe path for one item and update the shadow table
  function automatic table_reply_t probe_table(input logic op, input logic [31:0] key);
    table_reply_t reply;
    int unsigned  home;
    int unsigned  s;
    home = key % qpht_pkg::TABLE_SLOTS;
    reply.status = (op == qpht_pkg::OP_INSERT) ? qpht_pkg::RES_FULL : qpht_pkg::RES_NOT_FOUND;
    reply.slot = '0;
    if (op == qpht_pkg::OP_INSERT) begin
      if (shadow_fill < qpht_pkg::TABLE_SLOTS) begin
        for (int unsigned i = 0; i < qpht_pkg::TABLE_SLOTS; i++) begin
          s = (home + i * i) % qpht_pkg::TABLE_SLOTS;
          if (!shadow_valid[s]) begin
            shadow_keys[s] = key;
            shadow_valid[s] = 1'b1;
            shadow_fill = shadow_fill + 1'b1;
            reply.status = qpht_pkg::RES_INSERTED;
            reply.slot = s[qpht_pkg::SLOT_W-1:0];
            break;
          end
        end
      end
    end else begin
      for (int unsigned i = 0; i < qpht_pkg::TABLE_SLOTS; i++) begin
        s = (home + i * i) % qpht_pkg::TABLE_SLOTS;
        if (!shadow_valid[s]) break;
        if (shadow_keys[s] == key) begin
          reply.status = qpht_pkg::RES_FOUND;
          reply.slot = s[qpht_pkg::SLOT_W-1:0];
          break;
        end
      end
    end
    reply.occupied = shadow_fill;
    return reply;
  endfunction

  // Pick a key held in the table, or a fresh one while it is empty
  function automatic logic [31:0] held_key();
    int unsigned start;
    start = $urandom_range(0, qpht_pkg::TABLE_SLOTS - 1);
    for (int unsigned i = 0; i < qpht_pkg::TABLE_SLOTS; i++) begin
      if (shadow_valid[(start + i) % qpht_pkg::TABLE_SLOTS])
        return shadow_keys[(start + i) % qpht_pkg::TABLE_SLOTS];
    end
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Offer one item, hold it until the transfer, then record its expected result
  task automatic send_item(input logic op, input logic [31:0] key, input bit typed,
                           input table_reply_t given);
    table_reply_t reply;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reply = probe_table(op, key);
    replies_due.push_back(typed ? given : reply);
    items_sent++;
  endtask

  // Receiver: stall in random bursts while idling is on
  always @(posedge clk) begin
    if (!idle_on) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 2) != 0);
      stall_left <= $urandom_range(1, 15);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    table_reply_t exp_reply;
    if (!rst && m_tvalid && m_tready) begin
      status_seen[m_tuser]++;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, tuser %0d tdata %h",
                                  m_tuser, m_tdata));
      end else begin
        exp_reply = replies_due.pop_front();
        if (m_tuser !== exp_reply.status)
          report_mismatch($sformatf("status %0d, expected %s", m_tuser, exp_reply.status.name()));
        if (m_tdata[3:0] !== exp_reply.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", m_tdata[3:0], exp_reply.slot));
        if (m_tdata[8:4] !== exp_reply.occupied)
          report_mismatch($sformatf("occupied %0d, expected %0d", m_tdata[8:4],
                                    exp_reply.occupied));
        if (m_tdata[15:9] !== 7'd0)
          report_mismatch($sformatf("padding bits %h not zero", m_tdata[15:9]));
      end
    end
  end

  // Count cycles with no transfer on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles, %0d results pending", $realtime,
             QUIET_LIMIT, replies_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    table_reply_t none;
    logic         op;
    logic [31:0]  key;
    int           pick;
    none = '{qpht_pkg::RES_INSERTED, '0, '0};
    for (int i = 0; i < qpht_pkg::TABLE_SLOTS; i++) shadow_valid[i] = 1'b0;
    shadow_fill = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows
    for (int n = 0; n < N_DIR; n++)
      send_item(directed_rows[n].op, directed_rows[n].key, directed_rows[n].typed,
                directed_rows[n].reply);

    // Random: mostly searches for held keys, near misses and fresh keys; few inserts
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_CALM) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        op = qpht_pkg::OP_INSERT;
        key = ($urandom_range(0, 9) < 3) ? held_key() : $urandom;
      end else begin
        op = qpht_pkg::OP_SEARCH;
        if (pick < 60) key = held_key();
        else if (pick < 80) key = held_key() ^ ($urandom << qpht_pkg::SLOT_W);
        else key = $urandom;
      end
      send_item(op, key, 1'b0, none);
    end
    s_tvalid <= 1'b0;

    // Drain, then allow for a stray late result
    while (replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d items; final occupancy %0d of %0d slots", items_sent, shadow_fill,
             qpht_pkg::TABLE_SLOTS);
    $display("results seen: %0d inserted, %0d found, %0d not found, %0d full or no slot",
             status_seen[qpht_pkg::RES_INSERTED], status_seen[qpht_pkg::RES_FOUND],
             status_seen[qpht_pkg::RES_NOT_FOUND], status_seen[qpht_pkg::RES_FULL]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
